// File: src/dual_countdown_timer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual countdown timer
// Implication checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DUAL_COUNTDOWN_TIMER_ASSERT_SVH
`define DUAL_COUNTDOWN_TIMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define DCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DCT_ASSERT_IMP(lbl, ante, cons, msg)
`define DCT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/dct_pkg.sv
// ---------------------------------------------------------------------------
// dct_pkg
// Types, codes and defaults for the dual countdown timer.
// ---------------------------------------------------------------------------
package dct_pkg;

	localparam int NUM_TIMERS_DEF  = 2;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int DATA_W          = 32;
	localparam int IN_USER_W       = 6;
	localparam int OUT_DATA_W      = 40;

	// Control register bit positions
	localparam int CTL_ENABLE_BIT   = 7;
	localparam int CTL_PERIODIC_BIT = 6;
	localparam int CTL_INT_EN_BIT   = 5;
	localparam int CTL_PRE_LSB      = 2;
	localparam int CTL_WIDE_BIT     = 1;
	localparam int CTL_ONESHOT_BIT  = 0;

	localparam logic [7:0] CTL_WRITABLE = 8'hEF;
	localparam logic [7:0] CTL_RESET    = 8'h20;

	// Prescale codes
	localparam logic [1:0] PRE_DIV1  = 2'd0;
	localparam logic [1:0] PRE_DIV16 = 2'd1;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_LOAD   = 3'd0,
		REG_VALUE  = 3'd1,
		REG_CTRL   = 3'd2,
		REG_INTCLR = 3'd3,
		REG_RIS    = 3'd4,
		REG_MIS    = 3'd5,
		REG_BGLOAD = 3'd6,
		REG_RESV   = 3'd7
	} reg_t;

endpackage

// File: src/dual_countdown_timer.sv
// ---------------------------------------------------------------------------
// dual_countdown_timer
// Down-counting timers behind a word register map, driven by a beat stream.
// ---------------------------------------------------------------------------
// Each slave beat is one operation: a clock tick, a register read or a
// register write. tuser carries the operation kind, the timer select and
// the register index; tdata carries the write data. Each beat yields exactly
// one master beat with the read data (zero unless a read) and the masked
// interrupt of the first and second timers after the operation.
// Path: a beat is captured in the input register; when it advances, all
// timers update and the result register loads, which raises m_tvalid.
// Throughput: one beat per cycle while the receiver does not stall;
// back-to-back beats see each other's effects.
// Reset: all timers hold load zero, count all ones, control 0x20 (interrupt
// enable only), no pending interrupt, prescaler zero.
// Stall: while the receiver holds m_tready low the result holds; one more
// beat waits in the input register, after which s_tready drops.
// ---------------------------------------------------------------------------
module dual_countdown_timer #(
	parameter int NUM_TIMERS  = dct_pkg::NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = dct_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dct_pkg::DATA_W-1:0]    s_tdata,   // [31:0] write_data
	input  logic [dct_pkg::IN_USER_W-1:0] s_tuser,   // [1:0] mode, [2] timer_sel,
	                                                 // [5:3] reg_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dct_pkg::OUT_DATA_W-1:0] m_tdata   // [31:0] read_data,
	                                                 // [32] irq_first, [33] irq_second
);
	import dct_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] FULL_MASK = '1;
	localparam logic [COUNT_WIDTH-1:0] LOW_MASK  = COUNT_WIDTH'(16'hFFFF);

	`include "dual_countdown_timer_assert.svh"

	// Input stage
	logic                 valid_s1;
	mode_t                mode_s1;
	logic                 timer_sel_s1;
	reg_t                 reg_index_s1;
	logic [DATA_W-1:0]    write_data_s1;

	// Output stage
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// Timer state
	logic [COUNT_WIDTH-1:0] reload_q [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
	logic [7:0]             ctl_q    [NUM_TIMERS];
	logic                   raw_q    [NUM_TIMERS];
	logic [7:0]             pre_q    [NUM_TIMERS];

	logic [COUNT_WIDTH-1:0] reload_d [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] count_d  [NUM_TIMERS];
	logic [7:0]             ctl_d    [NUM_TIMERS];
	logic                   raw_d    [NUM_TIMERS];
	logic [7:0]             pre_d    [NUM_TIMERS];

	logic              advance;
	logic [DATA_W-1:0] read_data;
	logic              irq_first;
	logic              irq_second;

	// Handshake: stage one moves on when the result register is free
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1       <= mode_t'(s_tuser[1:0]);
			timer_sel_s1  <= s_tuser[2];
			reg_index_s1  <= reg_t'(s_tuser[5:3]);
			write_data_s1 <= s_tdata;
		end
	end

	// Next state of every timer
	always_comb begin
		logic [COUNT_WIDTH-1:0] mask;
		logic [COUNT_WIDTH-1:0] cnt;
		logic [COUNT_WIDTH-1:0] nxt;
		logic                   fire;
		logic                   hit;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			reload_d[t] = reload_q[t];
			count_d[t]  = count_q[t];
			ctl_d[t]    = ctl_q[t];
			raw_d[t]    = raw_q[t];
			pre_d[t]    = pre_q[t];
			mask = ctl_q[t][CTL_WIDE_BIT] ? FULL_MASK : LOW_MASK;
			cnt  = count_q[t] & mask;
			hit  = (32'(timer_sel_s1) == 32'(t));
			nxt  = '0;
			fire = 1'b0;
			if (advance) begin
				unique case (mode_s1)
					MODE_TICK: begin
						if (ctl_q[t][CTL_ENABLE_BIT]) begin
							pre_d[t] = pre_q[t] + 8'd1;
							case (ctl_q[t][CTL_PRE_LSB +: 2])
								PRE_DIV1:  fire = 1'b1;
								PRE_DIV16: fire = (pre_q[t][3:0] == 4'hF);
								default:   fire = (pre_q[t] == 8'hFF);
							endcase
							if (fire) begin
								if (cnt != '0) begin
									count_d[t] = cnt - COUNT_WIDTH'(1);
									if (cnt == COUNT_WIDTH'(1)) begin
										raw_d[t] = 1'b1;
									end
								end else if (ctl_q[t][CTL_ONESHOT_BIT]) begin
									count_d[t] = '0;
								end else begin
									nxt = ctl_q[t][CTL_PERIODIC_BIT] ?
										(reload_q[t] & mask) : mask;
									count_d[t] = nxt;
									if (nxt == '0) begin
										raw_d[t] = 1'b1;
									end
								end
							end
						end
					end
					MODE_WRITE: begin
						if (hit) begin
							case (reg_index_s1)
								REG_LOAD: begin
									reload_d[t] = write_data_s1[COUNT_WIDTH-1:0];
									count_d[t]  = write_data_s1[COUNT_WIDTH-1:0];
									pre_d[t]    = 8'd0;
								end
								REG_CTRL:   ctl_d[t]    = write_data_s1[7:0] & CTL_WRITABLE;
								REG_INTCLR: raw_d[t]    = 1'b0;
								REG_BGLOAD: reload_d[t] = write_data_s1[COUNT_WIDTH-1:0];
								default: ;
							endcase
						end
					end
					MODE_READ, MODE_NOP: ;
				endcase
			end
		end
	end

	// Register read mux
	always_comb begin
		read_data = '0;
		if (mode_s1 == MODE_READ) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (32'(timer_sel_s1) == 32'(t)) begin
					case (reg_index_s1)
						REG_LOAD, REG_BGLOAD: read_data = DATA_W'(reload_q[t]);
						REG_VALUE: read_data = DATA_W'(count_q[t] &
							(ctl_q[t][CTL_WIDE_BIT] ? FULL_MASK : LOW_MASK));
						REG_CTRL: read_data = DATA_W'(ctl_q[t]);
						REG_RIS:  read_data = DATA_W'(raw_q[t]);
						REG_MIS:  read_data = DATA_W'(raw_q[t] && ctl_q[t][CTL_INT_EN_BIT]);
						default:  read_data = '0;
					endcase
				end
			end
		end
	end

	// Masked interrupts after this beat
	assign irq_first = raw_d[0] && ctl_d[0][CTL_INT_EN_BIT];
	generate
		if (NUM_TIMERS > 1) begin : g_second
			assign irq_second = raw_d[1] && ctl_d[1][CTL_INT_EN_BIT];
		end else begin : g_no_second
			assign irq_second = 1'b0;
		end
	endgenerate

	// Hold timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				reload_q[t] <= '0;
				count_q[t]  <= FULL_MASK;
				ctl_q[t]    <= CTL_RESET;
				raw_q[t]    <= 1'b0;
				pre_q[t]    <= 8'd0;
			end
		end else begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				reload_q[t] <= reload_d[t];
				count_q[t]  <= count_d[t];
				ctl_q[t]    <= ctl_d[t];
				raw_q[t]    <= raw_d[t];
				pre_q[t]    <= pre_d[t];
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {6'd0, irq_second, irq_first, read_data};
		end
	end

	// Checks
	`DCT_ASSERT_IMP(a_stall_full, !s_tready, valid_s1 && m_tvalid_q, "stall without full pipe")
	`DCT_ASSERT_NXT(a_irq_match, advance, m_tdata_q[32] == (raw_q[0] && ctl_q[0][CTL_INT_EN_BIT]), "irq_first mismatch")
	`DCT_ASSERT_NXT(a_read_keeps, advance && mode_s1 == MODE_READ, count_q[0] == $past(count_q[0]), "read changed count")
	`DCT_ASSERT_IMP(a_raw_by_tick, $rose(raw_q[0]), $past(advance && mode_s1 == MODE_TICK), "interrupt raised outside tick")

endmodule
